### sv/buddy_page_allocator_macros.svh
// Assertion helpers for the buddy page allocator.
// Both expect clk and rst_n in scope.
`ifndef BUDDY_PAGE_ALLOCATOR_MACROS_SVH
`define BUDDY_PAGE_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS
`define BPA_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: %m");
`define BPA_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: %m");
`else
`define BPA_ASSERT_IMPL(name, ante, cons)
`define BPA_ASSERT_NEXT(name, ante, cons)
`endif

`endif

### sv/bpa_pkg.sv
package bpa_pkg;

    localparam int NUM_PAGES_DEF   = 1024;
    localparam int ORDER_LIMIT_DEF = 10;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MANAGED_PAGES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ORDER     = 1'b1;

    typedef enum logic [1:0] {
        FUNC_ALLOC       = 2'd0,
        FUNC_FREE        = 2'd1,
        FUNC_ADD_RANGE   = 2'd2,
        FUNC_ALLOC_EXACT = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_BLOCK = 2'd1,
        ST_REJECT   = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DISPATCH, S_SEARCH,
        S_UNL_A, S_UNL_B, S_UNL_C,
        S_SPLIT, S_APP_CHK, S_APP_W, S_APP_L,
        S_FREE_CHK, S_MERGE, S_MERGE_CHK, S_MERGE_UP,
        S_RANGE, S_DONE
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_CLEAR, OP_LOAD, OP_REJECT, OP_NOBLK,
        OP_ALLOC_INIT, OP_SEARCH_NEXT, OP_TAKE,
        OP_UNL_A, OP_UNL_B, OP_UNL_C,
        OP_APP_CUR, OP_APP_W, OP_APP_L,
        OP_SPLIT, OP_ALLOC_OK,
        OP_FREE_RD, OP_MERGE_RD, OP_MERGE_UP,
        OP_RANGE_STEP, OP_EMIT
    } op_t;

    typedef struct packed {
        op_t op;
    } ctrl_cmd_t;

    typedef struct packed {
        func_t func;
        logic  clr_done;
        logic  alloc_bad;
        logic  free_bad;
        logic  range_bad;
        logic  search_hit;
        logic  search_last;
        logic  split_more;
        logic  need_range;
        logic  rd_flag;
        logic  merge_more;
        logic  merge_match;
        logic  tail_ok;
        logic  range_more;
        logic  out_free;
    } dp_stat_t;

endpackage

### sv/bpa_req_if.sv
interface bpa_req_if #(
    parameter int PFN_W = 10,
    parameter int ORD_W = 4
);
    logic             valid;
    logic             ready;
    logic [1:0]       func;
    logic [ORD_W-1:0] order;
    logic [PFN_W-1:0] pfn;
    logic [PFN_W:0]   count;

    modport source (output valid, func, order, pfn, count, input ready);
    modport sink   (input valid, func, order, pfn, count, output ready);
endinterface

### sv/bpa_rsp_if.sv
interface bpa_rsp_if #(
    parameter int PFN_W = 10
);
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic [PFN_W-1:0] result_pfn;

    modport source (output valid, status, result_pfn, input ready);
    modport sink   (input valid, status, result_pfn, output ready);
endinterface

### sv/buddy_page_allocator.sv
// Binary buddy page allocator. One response item per request item: alloc (func 0) returns
// the first frame of a block of the given order, free (1) returns a block and merges it
// with free buddies, add range (2) frees a span as aligned blocks, alloc exact (3) takes
// the rounded-up order and hands the surplus back. After reset the block sweeps its page
// flag store page by page and takes no request until done; configuration writes
// are taken throughout but should only be issued while idle. One request is in flight at
// a time. The page store allows one read and one list update a cycle: an unlink walks
// the UNL_A, UNL_B and UNL_C states, an append APP_CHK, APP_W and, when the list has a
// tail, APP_L (plus an unlink when the frame already heads a block), and the order
// search tries one order per cycle. The response sits in an output register, so the
// next request is taken while the previous response waits.
module buddy_page_allocator #(
    parameter int NUM_PAGES   = bpa_pkg::NUM_PAGES_DEF,
    parameter int ORDER_LIMIT = bpa_pkg::ORDER_LIMIT_DEF,
    localparam int AW = $clog2(NUM_PAGES),
    localparam int PW = AW + 1,
    localparam int OW = $clog2(ORDER_LIMIT + 1),
    localparam int DW = (PW > OW) ? PW : OW
) (
    input  logic                          clk,
    input  logic                          rst_n,
    bpa_req_if.sink                       req,
    bpa_rsp_if.source                     rsp,
    input  logic                          cfg_we,
    input  logic [bpa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [DW-1:0]                 cfg_data
);

    // controller/datapath handshake
    bpa_pkg::ctrl_cmd_t cmd;
    bpa_pkg::dp_stat_t  stat;

    // sequencer: walks search, unlink, append, split, merge and range steps
    bpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // page store, per-order lists, configuration and response register
    bpa_datapath #(
        .NUM_PAGES   (NUM_PAGES),
        .ORDER_LIMIT (ORDER_LIMIT)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .req_func       (req.func),
        .req_order      (req.order),
        .req_pfn        (req.pfn),
        .req_count      (req.count),
        .rsp_ready      (rsp.ready),
        .rsp_valid      (rsp.valid),
        .rsp_status     (rsp.status),
        .rsp_result_pfn (rsp.result_pfn)
    );

endmodule

### sv/bpa_ctrl.sv
module bpa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  bpa_pkg::dp_stat_t  stat,
    output bpa_pkg::ctrl_cmd_t cmd
);

    bpa_pkg::state_t state_reg, state_next;
    bpa_pkg::state_t unl_ret_reg, unl_ret_next;
    bpa_pkg::state_t app_ret_reg, app_ret_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= bpa_pkg::S_CLEAR;
            unl_ret_reg <= bpa_pkg::S_IDLE;
            app_ret_reg <= bpa_pkg::S_IDLE;
        end
        else
        begin
            state_reg   <= state_next;
            unl_ret_reg <= unl_ret_next;
            app_ret_reg <= app_ret_next;
        end
    end

    // next state and return points
    always_comb
    begin
        state_next   = state_reg;
        unl_ret_next = unl_ret_reg;
        app_ret_next = app_ret_reg;
        case (state_reg)
            bpa_pkg::S_CLEAR:
                if (stat.clr_done) state_next = bpa_pkg::S_IDLE;
            bpa_pkg::S_IDLE:
                if (req_valid) state_next = bpa_pkg::S_DISPATCH;
            bpa_pkg::S_DISPATCH:
            begin
                case (stat.func)
                    bpa_pkg::FUNC_ALLOC, bpa_pkg::FUNC_ALLOC_EXACT:
                        state_next = stat.alloc_bad ? bpa_pkg::S_DONE : bpa_pkg::S_SEARCH;
                    bpa_pkg::FUNC_FREE:
                        state_next = stat.free_bad ? bpa_pkg::S_DONE : bpa_pkg::S_FREE_CHK;
                    default:
                        state_next = stat.range_bad ? bpa_pkg::S_DONE : bpa_pkg::S_RANGE;
                endcase
            end
            bpa_pkg::S_SEARCH:
            begin
                if (stat.search_hit)
                begin
                    state_next   = bpa_pkg::S_UNL_A;
                    unl_ret_next = bpa_pkg::S_SPLIT;
                end
                else if (stat.search_last)
                    state_next = bpa_pkg::S_DONE;
            end
            bpa_pkg::S_UNL_A: state_next = bpa_pkg::S_UNL_B;
            bpa_pkg::S_UNL_B: state_next = bpa_pkg::S_UNL_C;
            bpa_pkg::S_UNL_C: state_next = unl_ret_reg;
            bpa_pkg::S_SPLIT:
            begin
                if (stat.split_more)
                begin
                    state_next   = bpa_pkg::S_APP_CHK;
                    app_ret_next = bpa_pkg::S_SPLIT;
                end
                else if (stat.func == bpa_pkg::FUNC_ALLOC_EXACT && stat.need_range)
                    state_next = bpa_pkg::S_RANGE;
                else
                    state_next = bpa_pkg::S_DONE;
            end
            bpa_pkg::S_APP_CHK:
            begin
                if (stat.rd_flag)
                begin
                    state_next   = bpa_pkg::S_UNL_A;
                    unl_ret_next = bpa_pkg::S_APP_W;
                end
                else
                    state_next = bpa_pkg::S_APP_W;
            end
            bpa_pkg::S_APP_W:
                state_next = stat.tail_ok ? bpa_pkg::S_APP_L : app_ret_reg;
            bpa_pkg::S_APP_L: state_next = app_ret_reg;
            bpa_pkg::S_FREE_CHK:
                state_next = stat.rd_flag ? bpa_pkg::S_DONE : bpa_pkg::S_MERGE;
            bpa_pkg::S_MERGE:
            begin
                if (stat.merge_more)
                    state_next = bpa_pkg::S_MERGE_CHK;
                else
                begin
                    state_next   = bpa_pkg::S_APP_CHK;
                    app_ret_next = bpa_pkg::S_DONE;
                end
            end
            bpa_pkg::S_MERGE_CHK:
            begin
                if (stat.merge_match)
                begin
                    state_next   = bpa_pkg::S_UNL_A;
                    unl_ret_next = bpa_pkg::S_MERGE_UP;
                end
                else
                begin
                    state_next   = bpa_pkg::S_APP_CHK;
                    app_ret_next = bpa_pkg::S_DONE;
                end
            end
            bpa_pkg::S_MERGE_UP: state_next = bpa_pkg::S_MERGE;
            bpa_pkg::S_RANGE:
            begin
                if (stat.range_more)
                begin
                    state_next   = bpa_pkg::S_APP_CHK;
                    app_ret_next = bpa_pkg::S_RANGE;
                end
                else
                    state_next = bpa_pkg::S_DONE;
            end
            bpa_pkg::S_DONE:
                if (stat.out_free) state_next = bpa_pkg::S_IDLE;
            default: state_next = bpa_pkg::S_IDLE;
        endcase
    end

    // datapath commands
    always_comb
    begin
        cmd.op    = bpa_pkg::OP_NONE;
        req_ready = 1'b0;
        case (state_reg)
            bpa_pkg::S_CLEAR:
                if (!stat.clr_done) cmd.op = bpa_pkg::OP_CLEAR;
            bpa_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid) cmd.op = bpa_pkg::OP_LOAD;
            end
            bpa_pkg::S_DISPATCH:
            begin
                case (stat.func)
                    bpa_pkg::FUNC_ALLOC, bpa_pkg::FUNC_ALLOC_EXACT:
                        cmd.op = stat.alloc_bad ? bpa_pkg::OP_REJECT : bpa_pkg::OP_ALLOC_INIT;
                    bpa_pkg::FUNC_FREE:
                        cmd.op = stat.free_bad ? bpa_pkg::OP_REJECT : bpa_pkg::OP_FREE_RD;
                    default:
                        cmd.op = stat.range_bad ? bpa_pkg::OP_REJECT : bpa_pkg::OP_NONE;
                endcase
            end
            bpa_pkg::S_SEARCH:
            begin
                if (stat.search_hit)       cmd.op = bpa_pkg::OP_TAKE;
                else if (stat.search_last) cmd.op = bpa_pkg::OP_NOBLK;
                else                       cmd.op = bpa_pkg::OP_SEARCH_NEXT;
            end
            bpa_pkg::S_UNL_A: cmd.op = bpa_pkg::OP_UNL_A;
            bpa_pkg::S_UNL_B: cmd.op = bpa_pkg::OP_UNL_B;
            bpa_pkg::S_UNL_C: cmd.op = bpa_pkg::OP_UNL_C;
            bpa_pkg::S_SPLIT:
                cmd.op = stat.split_more ? bpa_pkg::OP_SPLIT : bpa_pkg::OP_ALLOC_OK;
            bpa_pkg::S_APP_W: cmd.op = bpa_pkg::OP_APP_W;
            bpa_pkg::S_APP_L: cmd.op = bpa_pkg::OP_APP_L;
            bpa_pkg::S_FREE_CHK:
                if (stat.rd_flag) cmd.op = bpa_pkg::OP_REJECT;
            bpa_pkg::S_MERGE:
                cmd.op = stat.merge_more ? bpa_pkg::OP_MERGE_RD : bpa_pkg::OP_APP_CUR;
            bpa_pkg::S_MERGE_CHK:
                if (!stat.merge_match) cmd.op = bpa_pkg::OP_APP_CUR;
            bpa_pkg::S_MERGE_UP: cmd.op = bpa_pkg::OP_MERGE_UP;
            bpa_pkg::S_RANGE:
                if (stat.range_more) cmd.op = bpa_pkg::OP_RANGE_STEP;
            bpa_pkg::S_DONE:
                if (stat.out_free) cmd.op = bpa_pkg::OP_EMIT;
            default: cmd.op = bpa_pkg::OP_NONE;
        endcase
    end

endmodule

### sv/bpa_datapath.sv
`include "buddy_page_allocator_macros.svh"

module bpa_datapath #(
    parameter int NUM_PAGES   = bpa_pkg::NUM_PAGES_DEF,
    parameter int ORDER_LIMIT = bpa_pkg::ORDER_LIMIT_DEF,
    localparam int AW = $clog2(NUM_PAGES),
    localparam int PW = AW + 1,
    localparam int OW = $clog2(ORDER_LIMIT + 1),
    localparam int DW = (PW > OW) ? PW : OW
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bpa_pkg::ctrl_cmd_t             cmd,
    output bpa_pkg::dp_stat_t              stat,
    input  logic                           cfg_we,
    input  logic [bpa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [DW-1:0]                  cfg_data,
    input  logic [1:0]                     req_func,
    input  logic [OW-1:0]                  req_order,
    input  logic [AW-1:0]                  req_pfn,
    input  logic [PW-1:0]                  req_count,
    input  logic                           rsp_ready,
    output logic                           rsp_valid,
    output logic [1:0]                     rsp_status,
    output logic [AW-1:0]                  rsp_result_pfn
);

    localparam int XW = (PW + 1 > ORDER_LIMIT + 2) ? PW + 1 : ORDER_LIMIT + 2;
    localparam int LW = $clog2(XW + 1);
    localparam logic [PW-1:0] NONE = PW'(NUM_PAGES);

    function automatic logic [LW-1:0] hi_bit(input logic [XW-1:0] v);
        logic [LW-1:0] r;
        r = '0;
        for (int i = 0; i < XW; i++)
            if (v[i]) r = LW'(i);
        return r;
    endfunction

    function automatic logic [LW-1:0] lo_bit(input logic [XW-1:0] v);
        logic [LW-1:0] r;
        r = '0;
        for (int i = XW - 1; i >= 0; i--)
            if (v[i]) r = LW'(i);
        return r;
    endfunction

    function automatic logic [XW-1:0] pow2(input logic [LW-1:0] o);
        return XW'(1) << o;
    endfunction

    // per-page store
    logic          flag_mem [NUM_PAGES];
    logic [OW-1:0] ord_mem  [NUM_PAGES];
    logic [PW-1:0] next_mem [NUM_PAGES];
    logic [PW-1:0] prev_mem [NUM_PAGES];

    // per-order list tails and lengths
    logic [PW-1:0] tail_reg [ORDER_LIMIT+1];
    logic [PW-1:0] fcnt_reg [ORDER_LIMIT+1];

    logic [PW-1:0] clr_reg;
    logic [PW-1:0] managed_reg;
    logic [OW-1:0] maxo_reg;
    logic          out_valid_reg;

    bpa_pkg::func_t   func_reg;
    bpa_pkg::status_t status_reg;
    logic [OW-1:0]    ord_reg;
    logic [PW-1:0]    cnt_reg;
    logic [XW-1:0]    cur_p_reg;
    logic [OW-1:0]    cur_o_reg;
    logic [OW-1:0]    req_o_reg;
    logic [XW-1:0]    n_reg;
    logic [AW-1:0]    ap_reg;
    logic [OW-1:0]    ao_reg;
    logic [PW-1:0]    t_reg;
    logic [AW-1:0]    where_reg;
    logic [AW-1:0]    rd_addr_reg;
    logic             rd_flag_reg;
    logic [OW-1:0]    rd_ord_reg;
    logic [PW-1:0]    rd_next_reg;
    logic [PW-1:0]    rd_prev_reg;
    logic [1:0]       out_status_reg;
    logic [AW-1:0]    out_pfn_reg;

    logic [PW-1:0] eff_mp;
    logic [OW-1:0] eff_mo;
    logic [XW-1:0] mp_x, cnt_x, bud, split_p;
    logic [LW-1:0] ceil_o, ro_w, lo_p;
    logic [OW-1:0] ro, so, alloc_o;
    logic          rd_en;
    logic [AW-1:0] rd_addr;

    always_comb
    begin
        eff_mp = (managed_reg > NONE) ? NONE : managed_reg;
        eff_mo = (maxo_reg > OW'(ORDER_LIMIT)) ? OW'(ORDER_LIMIT) : maxo_reg;
        mp_x   = XW'(eff_mp);
        cnt_x  = XW'(cnt_reg);

        ceil_o = hi_bit(cnt_x);
        if (pow2(ceil_o) < cnt_x) ceil_o = ceil_o + LW'(1);
        alloc_o = (func_reg == bpa_pkg::FUNC_ALLOC_EXACT) ? ceil_o[OW-1:0] : ord_reg;

        bud     = cur_p_reg ^ pow2(LW'(cur_o_reg));
        so      = cur_o_reg - OW'(1);
        split_p = cur_p_reg + pow2(LW'(so));

        // range piece: alignment of the start, pages left, order cap
        ro_w = hi_bit(n_reg);
        lo_p = lo_bit(cur_p_reg);
        if (cur_p_reg != '0 && lo_p < ro_w) ro_w = lo_p;
        if (ro_w > LW'(eff_mo)) ro_w = LW'(eff_mo);
        ro = ro_w[OW-1:0];
    end

    always_comb
    begin
        stat.func      = func_reg;
        stat.clr_done  = (clr_reg == NONE);
        if (func_reg == bpa_pkg::FUNC_ALLOC_EXACT)
            stat.alloc_bad = (cnt_reg == '0) || (ceil_o > LW'(eff_mo));
        else
            stat.alloc_bad = (ord_reg > eff_mo);
        stat.free_bad  = (ord_reg > eff_mo) || (cur_p_reg >= mp_x)
                       || ((cur_p_reg & (pow2(LW'(ord_reg)) - XW'(1))) != '0)
                       || (cur_p_reg + pow2(LW'(ord_reg)) > mp_x);
        stat.range_bad = (cnt_reg == '0) || (cur_p_reg >= mp_x)
                       || (cnt_x > mp_x - cur_p_reg);
        stat.search_hit  = (fcnt_reg[cur_o_reg] != '0) && (tail_reg[cur_o_reg] < NONE);
        stat.search_last = (cur_o_reg >= eff_mo);
        stat.split_more  = (cur_o_reg > req_o_reg);
        stat.need_range  = (pow2(LW'(req_o_reg)) > cnt_x);
        stat.rd_flag     = rd_flag_reg;
        stat.merge_more  = (cur_o_reg < eff_mo) && (bud < mp_x);
        stat.merge_match = rd_flag_reg && (rd_ord_reg == cur_o_reg);
        stat.tail_ok     = (tail_reg[ao_reg] < NONE);
        stat.range_more  = (n_reg != '0) && (cur_p_reg < XW'(NUM_PAGES));
        stat.out_free    = !out_valid_reg || rsp_ready;
    end

    always_comb
    begin
        rd_en   = 1'b1;
        rd_addr = cur_p_reg[AW-1:0];
        case (cmd.op)
            bpa_pkg::OP_TAKE:       rd_addr = tail_reg[cur_o_reg][AW-1:0];
            bpa_pkg::OP_FREE_RD:    rd_addr = cur_p_reg[AW-1:0];
            bpa_pkg::OP_MERGE_RD:   rd_addr = bud[AW-1:0];
            bpa_pkg::OP_APP_CUR:    rd_addr = cur_p_reg[AW-1:0];
            bpa_pkg::OP_SPLIT:      rd_addr = split_p[AW-1:0];
            bpa_pkg::OP_RANGE_STEP: rd_addr = cur_p_reg[AW-1:0];
            default:                rd_en   = 1'b0;
        endcase
    end

    // page store: one read and one write address per cycle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_addr_reg <= rd_addr;
            rd_flag_reg <= flag_mem[rd_addr];
            rd_ord_reg  <= ord_mem[rd_addr];
            rd_next_reg <= next_mem[rd_addr];
            rd_prev_reg <= prev_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            bpa_pkg::OP_CLEAR: flag_mem[clr_reg[AW-1:0]] <= 1'b0;
            bpa_pkg::OP_UNL_C: flag_mem[rd_addr_reg]     <= 1'b0;
            bpa_pkg::OP_APP_W: flag_mem[ap_reg]          <= 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == bpa_pkg::OP_APP_W)
            ord_mem[ap_reg] <= ao_reg;
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            bpa_pkg::OP_UNL_A:
                if (rd_prev_reg < NONE) next_mem[rd_prev_reg[AW-1:0]] <= rd_next_reg;
            bpa_pkg::OP_APP_W: next_mem[ap_reg] <= NONE;
            bpa_pkg::OP_APP_L: next_mem[t_reg[AW-1:0]] <= PW'(ap_reg);
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            bpa_pkg::OP_UNL_B:
                if (rd_next_reg < NONE) prev_mem[rd_next_reg[AW-1:0]] <= rd_prev_reg;
            bpa_pkg::OP_APP_W: prev_mem[ap_reg] <= tail_reg[ao_reg];
            default: ;
        endcase
    end

    // control state, configuration and list tails
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            managed_reg   <= PW'(NUM_PAGES);
            maxo_reg      <= OW'(ORDER_LIMIT);
            out_valid_reg <= 1'b0;
            for (int i = 0; i <= ORDER_LIMIT; i++)
            begin
                tail_reg[i] <= NONE;
                fcnt_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    bpa_pkg::CFG_MANAGED_PAGES: managed_reg <= cfg_data[PW-1:0];
                    bpa_pkg::CFG_MAX_ORDER:     maxo_reg    <= cfg_data[OW-1:0];
                    default: ;
                endcase
            end
            if (cmd.op == bpa_pkg::OP_EMIT)
                out_valid_reg <= 1'b1;
            else if (rsp_ready)
                out_valid_reg <= 1'b0;
            case (cmd.op)
                bpa_pkg::OP_CLEAR: clr_reg <= clr_reg + PW'(1);
                bpa_pkg::OP_UNL_B:
                begin
                    if (rd_next_reg >= NONE) tail_reg[rd_ord_reg] <= rd_prev_reg;
                    if (fcnt_reg[rd_ord_reg] != '0)
                        fcnt_reg[rd_ord_reg] <= fcnt_reg[rd_ord_reg] - PW'(1);
                end
                bpa_pkg::OP_APP_W:
                begin
                    tail_reg[ao_reg] <= PW'(ap_reg);
                    fcnt_reg[ao_reg] <= fcnt_reg[ao_reg] + PW'(1);
                end
                default: ;
            endcase
        end
    end

    // work registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            bpa_pkg::OP_LOAD:
            begin
                func_reg   <= bpa_pkg::func_t'(req_func);
                ord_reg    <= req_order;
                cnt_reg    <= req_count;
                cur_p_reg  <= XW'(req_pfn);
                cur_o_reg  <= req_order;
                n_reg      <= XW'(req_count);
                status_reg <= bpa_pkg::ST_OK;
                where_reg  <= '0;
            end
            bpa_pkg::OP_REJECT: status_reg <= bpa_pkg::ST_REJECT;
            bpa_pkg::OP_NOBLK:  status_reg <= bpa_pkg::ST_NO_BLOCK;
            bpa_pkg::OP_ALLOC_INIT:
            begin
                req_o_reg <= alloc_o;
                cur_o_reg <= alloc_o;
            end
            bpa_pkg::OP_SEARCH_NEXT: cur_o_reg <= cur_o_reg + OW'(1);
            bpa_pkg::OP_TAKE:        cur_p_reg <= XW'(tail_reg[cur_o_reg]);
            bpa_pkg::OP_SPLIT:
            begin
                cur_o_reg <= so;
                ao_reg    <= so;
                ap_reg    <= split_p[AW-1:0];
            end
            bpa_pkg::OP_ALLOC_OK:
            begin
                where_reg <= cur_p_reg[AW-1:0];
                cur_p_reg <= cur_p_reg + cnt_x;
                n_reg     <= pow2(LW'(req_o_reg)) - cnt_x;
            end
            bpa_pkg::OP_APP_CUR:
            begin
                ap_reg <= cur_p_reg[AW-1:0];
                ao_reg <= cur_o_reg;
            end
            bpa_pkg::OP_APP_W: t_reg <= tail_reg[ao_reg];
            bpa_pkg::OP_MERGE_UP:
            begin
                cur_p_reg <= cur_p_reg & ~pow2(LW'(cur_o_reg));
                cur_o_reg <= cur_o_reg + OW'(1);
            end
            bpa_pkg::OP_RANGE_STEP:
            begin
                ap_reg    <= cur_p_reg[AW-1:0];
                ao_reg    <= ro;
                cur_p_reg <= cur_p_reg + pow2(ro_w);
                n_reg     <= n_reg - pow2(ro_w);
            end
            bpa_pkg::OP_EMIT:
            begin
                out_status_reg <= status_reg;
                out_pfn_reg    <= (status_reg == bpa_pkg::ST_OK) ? where_reg : '0;
            end
            default: ;
        endcase
    end

    assign rsp_valid      = out_valid_reg;
    assign rsp_status     = out_status_reg;
    assign rsp_result_pfn = out_pfn_reg;

    `BPA_ASSERT_IMPL(a_load_after_clear, cmd.op == bpa_pkg::OP_LOAD, clr_reg == NONE)
    `BPA_ASSERT_IMPL(a_emit_slot_free, cmd.op == bpa_pkg::OP_EMIT, !out_valid_reg || rsp_ready)
    `BPA_ASSERT_NEXT(a_emit_shows, cmd.op == bpa_pkg::OP_EMIT, out_valid_reg)
    `BPA_ASSERT_IMPL(a_fail_zero_pfn, out_valid_reg && out_status_reg != bpa_pkg::ST_OK, out_pfn_reg == '0)
    `BPA_ASSERT_IMPL(a_take_nonempty, cmd.op == bpa_pkg::OP_TAKE, tail_reg[cur_o_reg] < NONE)

endmodule

### bench/bpa_checker.sv
`timescale 1ns / 1ps

// Watches the request, response and config channels, keeps its own copy of
// the free lists and checks every response item in order.
module bpa_checker (
    input  logic        clk,
    input  logic        rst_n,
    bpa_req_if          req,
    bpa_rsp_if          rsp,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [10:0] cfg_data,
    output int          errors
);

    localparam int NP   = 1024;
    localparam int OLIM = 10;

    typedef struct {
        logic [1:0] status;
        logic [9:0] pfn;
    } reply_t;

    reply_t replies_due[$];

    int unsigned pages_cfg;
    int unsigned order_cap;
    bit          page_free [NP];
    int unsigned page_ord  [NP];
    int unsigned fwd       [NP];
    int unsigned bwd       [NP];
    int unsigned list_first[OLIM+1];
    int unsigned list_last [OLIM+1];
    int unsigned list_len  [OLIM+1];

    function automatic int unsigned eff_pages();
        return (pages_cfg > NP) ? NP : pages_cfg;
    endfunction

    function automatic int unsigned eff_order_cap();
        return (order_cap > OLIM) ? OLIM : order_cap;
    endfunction

    function automatic int unsigned flog2(int unsigned v);
        int unsigned r;
        r = 0;
        while (v > 1)
        begin
            v = v >> 1;
            r++;
        end
        return r;
    endfunction

    function automatic void unlink_block(int unsigned p);
        int unsigned o, nx, pv;
        if (p >= NP || !page_free[p])
            return;
        o  = (page_ord[p] > OLIM) ? OLIM : page_ord[p];
        nx = fwd[p];
        pv = bwd[p];
        if (pv < NP)
            fwd[pv] = nx;
        else
            list_first[o] = nx;
        if (nx < NP)
            bwd[nx] = pv;
        else
            list_last[o] = pv;
        if (list_len[o] > 0)
            list_len[o]--;
        page_free[p] = 0;
    endfunction

    function automatic void append_block(int unsigned p, int unsigned o);
        int unsigned t;
        if (p >= NP || o > OLIM)
            return;
        if (page_free[p])
            unlink_block(p);
        t            = list_last[o];
        page_free[p] = 1;
        page_ord[p]  = o;
        fwd[p]       = NP;
        bwd[p]       = t;
        if (t < NP)
            fwd[t] = p;
        else
            list_first[o] = p;
        list_last[o] = p;
        list_len[o]++;
    endfunction

    function automatic void free_span(int unsigned p, int unsigned n);
        int unsigned mo, o, low;
        mo = eff_order_cap();
        while (n > 0 && p < NP)
        begin
            o = flog2(n);
            if (p != 0)
            begin
                low = 0;
                while (((p >> low) & 1) == 0)
                    low++;
                if (low < o)
                    o = low;
            end
            if (o > mo)
                o = mo;
            append_block(p, o);
            p += (1 << o);
            n -= (1 << o);
        end
    endfunction

    function automatic bpa_pkg::status_t take_block(int unsigned want, output int unsigned at);
        int unsigned mo, o, p;
        mo = eff_order_cap();
        at = 0;
        if (want > mo)
            return bpa_pkg::ST_REJECT;
        for (o = want; o <= mo; o++)
            if (list_len[o] > 0 && list_last[o] < NP)
                break;
        if (o > mo)
            return bpa_pkg::ST_NO_BLOCK;
        p = list_last[o];
        unlink_block(p);
        while (o > want)
        begin
            o--;
            append_block(p + (1 << o), o);
        end
        at = p;
        return bpa_pkg::ST_OK;
    endfunction

    function automatic bpa_pkg::status_t give_back(int unsigned p, int unsigned o);
        int unsigned mo, mp, b;
        mo = eff_order_cap();
        mp = eff_pages();
        if (o > mo || p >= mp || (p & ((1 << o) - 1)) != 0)
            return bpa_pkg::ST_REJECT;
        if (p + (1 << o) > mp || page_free[p])
            return bpa_pkg::ST_REJECT;
        while (o < mo)
        begin
            b = p ^ (1 << o);
            if (b >= mp || !page_free[b] || page_ord[b] != o)
                break;
            unlink_block(b);
            p = p & ~(1 << o);
            o++;
        end
        append_block(p, o);
        return bpa_pkg::ST_OK;
    endfunction

    function automatic reply_t predict_reply(bpa_pkg::func_t f, int unsigned o,
                                             int unsigned p, int unsigned c);
        reply_t           r;
        int unsigned      at, mp, ro;
        bpa_pkg::status_t st;
        at = 0;
        st = bpa_pkg::ST_REJECT;
        case (f)
            bpa_pkg::FUNC_ALLOC:
                st = take_block(o, at);
            bpa_pkg::FUNC_FREE:
                st = give_back(p, o);
            bpa_pkg::FUNC_ADD_RANGE:
            begin
                mp = eff_pages();
                if (c != 0 && p < mp && c <= mp - p)
                begin
                    free_span(p, c);
                    st = bpa_pkg::ST_OK;
                end
            end
            default:
                if (c != 0)
                begin
                    ro = flog2(c);
                    if ((1 << ro) < c)
                        ro++;
                    st = take_block(ro, at);
                    // surplus pages past the count go straight back
                    if (st == bpa_pkg::ST_OK && (1 << ro) > c)
                        free_span(at + c, (1 << ro) - c);
                end
        endcase
        r.status = st;
        r.pfn    = (st == bpa_pkg::ST_OK) ? at[9:0] : 10'd0;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        if (!rst_n)
        begin
            errors    <= 0;
            pages_cfg  = 1024;
            order_cap  = 10;
            replies_due.delete();
            for (int i = 0; i < NP; i++)
            begin
                page_free[i] = 0;
                page_ord[i]  = 0;
                fwd[i]       = NP;
                bwd[i]       = NP;
            end
            for (int i = 0; i <= OLIM; i++)
            begin
                list_first[i] = NP;
                list_last[i]  = NP;
                list_len[i]   = 0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == bpa_pkg::CFG_MANAGED_PAGES)
                    pages_cfg = cfg_data[10:0];
                else if (cfg_index == bpa_pkg::CFG_MAX_ORDER)
                    order_cap = cfg_data[3:0];
            end
            if (req.valid && req.ready)
                replies_due.push_back(predict_reply(bpa_pkg::func_t'(req.func), req.order,
                                                    req.pfn, req.count));
            if (rsp.valid && rsp.ready)
            begin
                if (replies_due.size() == 0)
                begin
                    $display("%0t: unexpected item status=%0d pfn=%0d", $time,
                             rsp.status, rsp.result_pfn);
                    errors <= errors + 1;
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (rsp.status !== want.status || rsp.result_pfn !== want.pfn)
                    begin
                        $display("%0t: mismatch expected status=%0d pfn=%0d, got status=%0d pfn=%0d",
                                 $time, want.status, want.pfn, rsp.status, rsp.result_pfn);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

    function automatic int pending();
        return replies_due.size();
    endfunction
endmodule

### bench/tb_buddy_page_allocator.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the buddy page allocator. The checker beside the
// block does all prediction; this module drives items, config and ready, and
// keeps a rough list of blocks it holds so that most frees are well formed.
module tb_buddy_page_allocator;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [10:0] cfg_data;
    int          errors;

    bpa_req_if req ();
    bpa_rsp_if rsp ();

    buddy_page_allocator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bpa_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors)
    );

    // 20 ns period
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // blocks believed held, learnt from ok responses
    typedef struct {
        logic [9:0] pfn;
        logic [3:0] ord;
    } held_t;
    typedef struct {
        bpa_pkg::func_t f;
        logic [3:0]     ord;
    } sent_t;

    held_t held[$];
    sent_t in_flight[$];
    int    n_out;
    int    idle_cycles;
    int    burst_left;

    // item bookkeeping on the rising edge, same sampling as the checker
    always @(posedge clk)
    begin
        sent_t s;
        held_t h;
        if (rst_n)
        begin
            if (req.valid && req.ready)
            begin
                s.f   = bpa_pkg::func_t'(req.func);
                s.ord = req.order;
                in_flight.push_back(s);
                n_out++;
            end
            if (rsp.valid && rsp.ready && in_flight.size() > 0)
            begin
                s = in_flight.pop_front();
                n_out--;
                if (rsp.status == bpa_pkg::ST_OK
                    && (s.f == bpa_pkg::FUNC_ALLOC || s.f == bpa_pkg::FUNC_ALLOC_EXACT))
                begin
                    h.pfn = rsp.result_pfn;
                    // an exact alloc is only known to hold its first frame
                    h.ord = (s.f == bpa_pkg::FUNC_ALLOC) ? s.ord : 4'd0;
                    held.push_back(h);
                end
            end
        end
    end

    // watchdog: cycles with nothing moving on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver: modes of always ready, coin toss and mostly stalled
    always @(negedge clk)
    begin
        int mode;
        mode = int'(($time / 1280) % 3);
        if (!rst_n)
            rsp.ready <= 1'b0;
        else if (mode == 0)
            rsp.ready <= 1'b1;
        else if (mode == 1)
            rsp.ready <= ($urandom_range(0, 1) == 1);
        else
            rsp.ready <= ($urandom_range(0, 3) == 0);
    end

    task automatic send_item(bpa_pkg::func_t f, logic [3:0] o, logic [9:0] p, logic [10:0] c);
        req.valid <= 1'b1;
        req.func  <= f;
        req.order <= o;
        req.pfn   <= p;
        req.count <= c;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 8))
                @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : int'($urandom_range(1, 12));
        end
    endtask

    task automatic write_reg(logic [0:0] idx, logic [10:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // drain: stop sending, every response in, then allow for the slowest item
    task automatic wait_quiet();
        req.valid <= 1'b0;
        while (n_out != 0)
            @(posedge clk);
        repeat (200)
            @(posedge clk);
        @(negedge clk);
    endtask

    // one random item, mostly well formed alloc/free traffic
    task automatic random_item();
        int    pick;
        int    k;
        held_t h;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            send_item(bpa_pkg::FUNC_ALLOC,
                      4'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                     : $urandom_range(0, 3)),
                      10'($urandom), 11'($urandom));
        else if (pick < 75 && held.size() > 0)
        begin
            k = $urandom_range(0, held.size() - 1);
            h = held[k];
            held.delete(k);
            send_item(bpa_pkg::FUNC_FREE, h.ord, h.pfn, 11'($urandom));
        end
        else if (pick < 82)
            // noise free: often misaligned or already free
            send_item(bpa_pkg::FUNC_FREE, 4'($urandom_range(0, 15)), 10'($urandom),
                      11'($urandom));
        else if (pick < 90)
            send_item(bpa_pkg::FUNC_ADD_RANGE, 4'($urandom), 10'($urandom),
                      11'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047)
                                                      : $urandom_range(0, 40)));
        else
            send_item(bpa_pkg::FUNC_ALLOC_EXACT, 4'($urandom), 10'($urandom),
                      11'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047)
                                                      : $urandom_range(0, 24)));
    endtask

    initial
    begin
        int pages_set [5];
        int order_set [5];
        pages_set = '{1024, 600, 1, 2047, 1000};
        order_set = '{10, 7, 0, 15, 3};

        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = bpa_pkg::CFG_MANAGED_PAGES;
        cfg_data    = '0;
        req.valid   = 1'b0;
        req.func    = bpa_pkg::FUNC_ALLOC;
        req.order   = '0;
        req.pfn     = '0;
        req.count   = '0;
        n_out       = 0;
        burst_left  = 5;
        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_reg(bpa_pkg::CFG_MANAGED_PAGES, 11'd1024);
        write_reg(bpa_pkg::CFG_MAX_ORDER, 11'd10);

        // directed: empty allocator, rejects, whole-span range, extremes
        send_item(bpa_pkg::FUNC_ALLOC, 4'd0, 10'd0, 11'd0);
        send_item(bpa_pkg::FUNC_ALLOC_EXACT, 4'd0, 10'd0, 11'd1);
        send_item(bpa_pkg::FUNC_ALLOC, 4'd11, 10'd0, 11'd0);
        send_item(bpa_pkg::FUNC_ALLOC, 4'd15, 10'd0, 11'd0);
        send_item(bpa_pkg::FUNC_ALLOC_EXACT, 4'd0, 10'd0, 11'd0);
        send_item(bpa_pkg::FUNC_ALLOC_EXACT, 4'd0, 10'd0, 11'd1025);
        send_item(bpa_pkg::FUNC_ADD_RANGE, 4'd0, 10'd0, 11'd0);
        send_item(bpa_pkg::FUNC_ADD_RANGE, 4'd0, 10'd1023, 11'd2);
        send_item(bpa_pkg::FUNC_ADD_RANGE, 4'd0, 10'd0, 11'd2047);
        send_item(bpa_pkg::FUNC_ADD_RANGE, 4'd0, 10'd0, 11'd1024);
        send_item(bpa_pkg::FUNC_ALLOC, 4'd10, 10'd0, 11'd0);
        send_item(bpa_pkg::FUNC_FREE, 4'd10, 10'd0, 11'd0);
        send_item(bpa_pkg::FUNC_FREE, 4'd10, 10'd0, 11'd0);
        send_item(bpa_pkg::FUNC_ALLOC_EXACT, 4'd0, 10'd0, 11'd1024);
        send_item(bpa_pkg::FUNC_ADD_RANGE, 4'd0, 10'd5, 11'd1019);
        send_item(bpa_pkg::FUNC_ALLOC_EXACT, 4'd0, 10'd0, 11'd3);
        send_item(bpa_pkg::FUNC_FREE, 4'd1, 10'd1, 11'd0);
        send_item(bpa_pkg::FUNC_FREE, 4'd15, 10'd0, 11'd0);
        send_item(bpa_pkg::FUNC_FREE, 4'd1, 10'd1022, 11'd0);
        send_item(bpa_pkg::FUNC_ADD_RANGE, 4'd0, 10'd1023, 11'd1);
        send_item(bpa_pkg::FUNC_ADD_RANGE, 4'd0, 10'd1023, 11'd1);
        send_item(bpa_pkg::FUNC_ALLOC, 4'd0, 10'd1023, 11'd0);
        send_item(bpa_pkg::FUNC_FREE, 4'd0, 10'd1023, 11'd0);
        send_item(bpa_pkg::FUNC_ALLOC_EXACT, 4'd0, 10'd0, 11'd1000);

        // phases over config settings; each starts by freeing the managed span
        for (int ph = 0; ph < 5; ph++)
        begin
            wait_quiet();
            write_reg(bpa_pkg::CFG_MANAGED_PAGES, 11'(pages_set[ph]));
            write_reg(bpa_pkg::CFG_MAX_ORDER, 11'(order_set[ph]));
            held.delete();
            send_item(bpa_pkg::FUNC_ADD_RANGE, 4'd0, 10'd0,
                      (pages_set[ph] > 1024) ? 11'd1024 : 11'(pages_set[ph]));
            for (int i = 0; i < 190; i++)
                random_item();
        end

        req.valid <= 1'b0;
        wait_quiet();
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

### buddy_page_allocator.f
+incdir+sv
sv/bpa_pkg.sv
sv/bpa_req_if.sv
sv/bpa_rsp_if.sv
sv/bpa_ctrl.sv
sv/bpa_datapath.sv
sv/buddy_page_allocator.sv
bench/bpa_checker.sv
bench/tb_buddy_page_allocator.sv
